// ===== rtl/core/kvt_pkg.sv =====
`default_nettype none

package kvt_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VALUE_W    = 32;

  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned KEY_PORT_W = 32;
  localparam int unsigned VAL_PORT_W = 32;
  localparam int unsigned CNT_PORT_W = 5;
  localparam int unsigned LIM_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_UPSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_LOOKUP = 3'd4
  } kvt_op_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_FILL,
    ACT_SET,
    ACT_CLEAR
  } kvt_act_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [VALUE_W-1:0] hit_val;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
  } kvt_tok_t;

  typedef struct packed {
    kvt_act_e           act;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] val;
  } kvt_wr_t;

  typedef struct packed {
    logic busy;
    logic commit;
  } kvt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/kvt_cell.sv =====
`default_nettype none

module kvt_cell
  import kvt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire logic [CAP_W-1:0] limit_i,
  input  wire kvt_tok_t         tok_i,
  output kvt_tok_t              tok_o,
  input  wire kvt_wr_t          wr_i
);

  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic               used_q;
  kvt_tok_t           tok_d;
  kvt_tok_t           tok_q;
  logic               vld_q;
  logic               in_lim;
  logic               match;
  logic               sel;

  assign in_lim = LIM_W'(cell_idx_i) < LIM_W'(limit_i);
  assign match  = used_q && in_lim && (key_q == tok_i.key);
  assign sel    = (wr_i.act != ACT_NONE) && (wr_i.idx == cell_idx_i);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && match) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = cell_idx_i;
      tok_d.hit_val = val_q;
    end
    if (!tok_i.free && in_lim && !used_q) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (sel && (wr_i.act == ACT_FILL)) begin
      key_q <= wr_i.key;
    end
    if (sel && ((wr_i.act == ACT_FILL) || (wr_i.act == ACT_SET))) begin
      val_q <= wr_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      used_q <= 1'b0;
    end else begin
      vld_q <= tok_d.valid;
      if (sel && (wr_i.act == ACT_FILL)) begin
        used_q <= 1'b1;
      end else if (sel && (wr_i.act == ACT_CLEAR)) begin
        used_q <= 1'b0;
      end
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = vld_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kvt_ctrl.sv =====
`default_nettype none

module kvt_ctrl
  import kvt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OP_W-1:0]       opcode_i,
  input  wire logic [KEY_PORT_W-1:0] key_i,
  input  wire logic [VAL_PORT_W-1:0] value_in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       success_o,
  output logic [VAL_PORT_W-1:0]      value_out_o,
  output logic [CNT_PORT_W-1:0]      entry_count_o,
  output logic                       is_empty_o,
  output kvt_tok_t                   tok_o,
  input  wire kvt_tok_t              tok_i,
  output kvt_wr_t                    wr_o,
  output kvt_stat_t                  stat_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e             state_q;
  kvt_op_e            op_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic               tok_vld_q;
  kvt_tok_t           fin_q;
  logic [CNT_W-1:0]   used_count_q;
  logic [CNT_W-1:0]   count_d;
  logic               ok_d;
  logic [VALUE_W-1:0] vout_d;
  logic               commit;
  logic               res_valid_q;
  logic               res_ok_q;
  logic [VALUE_W-1:0] res_val_q;
  logic [CNT_W-1:0]   res_cnt_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign commit     = (state_q == ST_DONE) && (!res_valid_q || out_ready_i);

  always_comb begin
    tok_o          = '0;
    tok_o.valid    = tok_vld_q;
    tok_o.key      = key_q;
  end

  always_comb begin
    wr_o     = '0;
    wr_o.act = ACT_NONE;
    wr_o.key = key_q;
    wr_o.val = val_q;
    wr_o.idx = fin_q.hit_idx;
    count_d  = used_count_q;
    ok_d     = 1'b0;
    vout_d   = '0;
    case (op_q)
      OP_INSERT: begin
        if (!fin_q.hit && fin_q.free) begin
          wr_o.act = ACT_FILL;
          wr_o.idx = fin_q.free_idx;
          count_d  = CNT_W'(used_count_q + 1'b1);
          ok_d     = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (fin_q.hit) begin
          wr_o.act = ACT_SET;
          ok_d     = 1'b1;
        end
      end
      OP_UPSERT: begin
        if (fin_q.hit) begin
          wr_o.act = ACT_SET;
          ok_d     = 1'b1;
        end else if (fin_q.free) begin
          wr_o.act = ACT_FILL;
          wr_o.idx = fin_q.free_idx;
          count_d  = CNT_W'(used_count_q + 1'b1);
          ok_d     = 1'b1;
        end
      end
      OP_ERASE: begin
        if (fin_q.hit) begin
          wr_o.act = ACT_CLEAR;
          count_d  = CNT_W'(used_count_q - 1'b1);
          ok_d     = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (fin_q.hit) begin
          vout_d = fin_q.hit_val;
          ok_d   = 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (!commit) begin
      wr_o.act = ACT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tok_vld_q    <= 1'b0;
      used_count_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      tok_vld_q <= (state_q == ST_IDLE) && in_valid_i;
      if (commit) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q      <= kvt_op_e'(opcode_i);
            key_q     <= KEY_W'(key_i);
            val_q     <= VALUE_W'(value_in_i);
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok_i.valid) begin
            fin_q   <= tok_i;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (commit) begin
            used_count_q <= count_d;
            res_ok_q     <= ok_d;
            res_val_q    <= vout_d;
            res_cnt_q    <= count_d;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = res_valid_q;
  assign success_o     = res_ok_q;
  assign value_out_o   = VAL_PORT_W'(res_val_q);
  assign entry_count_o = CNT_PORT_W'(res_cnt_q);
  assign is_empty_o    = (res_cnt_q == '0);

  assign stat_o.busy   = (state_q != ST_IDLE);
  assign stat_o.commit = commit;

endmodule

`default_nettype wire

// ===== rtl/core/fixed_capacity_key_value_table.sv =====
// Associative table of sixteen key/value slots with a used mark per slot.
// An operation request (opcode, key, value_in) is taken on the in_valid_i /
// in_ready_o channel; its one result (success, value_out, entry_count,
// is_empty) leaves on the out_valid_o / out_ready_i channel.
// A search token walks the row of slot cells, one cell per cycle, picking up
// the first matching used slot and the lowest free slot below the capacity
// limit. The result is registered once the token has left the last cell and
// the controller has committed the operation; a new request is taken only
// after that commit, so the walk along the row sets the pace of requests.
// One request is in work at a time.
// The capacity register is written on the cfg_valid_i / cfg_ready_o channel
// and should only be written while the table is idle.
// Reset clears every used mark, the entry count and the result valid flag, and
// sets the capacity to sixteen.
// If the receiver stalls, the finished result is held in the output register
// and a further request may still be taken and searched; its changes are
// committed only once the held result has gone.
`default_nettype none

module fixed_capacity_key_value_table
  import kvt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CAP_W-1:0]      cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OP_W-1:0]       opcode_i,
  input  wire logic [KEY_PORT_W-1:0] key_i,
  input  wire logic [VAL_PORT_W-1:0] value_in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       success_o,
  output logic [VAL_PORT_W-1:0]      value_out_o,
  output logic [CNT_PORT_W-1:0]      entry_count_o,
  output logic                       is_empty_o
);

  logic [CAP_W-1:0] cap_q;
  kvt_tok_t         tok [0:DEPTH];
  kvt_wr_t          wr;
  kvt_stat_t        stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  kvt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_in_i    (value_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_o     (success_o),
    .value_out_o   (value_out_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .tok_o         (tok[0]),
    .tok_i         (tok[DEPTH]),
    .wr_o          (wr),
    .stat_o        (stat)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    kvt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .limit_i    (cap_q),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .wr_i       (wr)
    );
  end

  a_commit_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.commit |=> out_valid_o)
    else $error("Commit did not load a result.");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && stat.busy))
    else $error("Request taken while another is in work.");

  a_write_only_on_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.act != ACT_NONE) |-> stat.commit)
    else $error("Slot write outside a commit.");

  a_no_commit_over_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !stat.commit)
    else $error("Commit while a result is still held.");

endmodule

`default_nettype wire

// ===== verif/tb_fixed_capacity_key_value_table.sv =====
module tb_fixed_capacity_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic                  success;
    logic [VAL_PORT_W-1:0] value;
    logic [CNT_PORT_W-1:0] count;
    logic                  empty;
  } kv_result_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CAP_W-1:0]      cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [OP_W-1:0]       opcode_i    = OP_LOOKUP;
  logic [KEY_PORT_W-1:0] key_i       = '0;
  logic [VAL_PORT_W-1:0] value_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  success_o;
  logic [VAL_PORT_W-1:0] value_out_o;
  logic [CNT_PORT_W-1:0] entry_count_o;
  logic                  is_empty_o;

  fixed_capacity_key_value_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_in_i    (value_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_o     (success_o),
    .value_out_o   (value_out_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  logic [KEY_W-1:0]   kv_key  [DEPTH];
  logic [VALUE_W-1:0] kv_val  [DEPTH];
  bit                 kv_used [DEPTH];
  int unsigned        kv_count;
  logic [CAP_W-1:0]   kv_cap;

  kv_result_t awaited_results[$];

  int unsigned request_total;
  int unsigned success_total;
  int unsigned result_total;
  int unsigned mismatch_total;
  int unsigned cap_write_total;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still awaited.", awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void store_entry(input int idx, input logic [KEY_W-1:0] key,
                                      input logic [VALUE_W-1:0] val);
    kv_key[idx]  = key;
    kv_val[idx]  = val;
    kv_used[idx] = 1'b1;
    kv_count++;
  endfunction

  function automatic kv_result_t apply_table_op(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [VALUE_W-1:0] val);
    int unsigned lim;
    int          hit_at;
    int          free_at;
    kv_result_t  res;
    lim     = (kv_cap > DEPTH) ? DEPTH : kv_cap;
    hit_at  = -1;
    free_at = -1;
    res     = '0;
    for (int i = 0; i < lim; i++) begin
      if (kv_used[i] && kv_key[i] == key && hit_at < 0) hit_at = i;
      if (!kv_used[i] && free_at < 0) free_at = i;
    end
    case (op)
      OP_INSERT: begin
        if (hit_at < 0 && free_at >= 0) begin
          store_entry(free_at, key, val);
          res.success = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (hit_at >= 0) begin
          kv_val[hit_at] = val;
          res.success = 1'b1;
        end
      end
      OP_UPSERT: begin
        if (hit_at >= 0) begin
          kv_val[hit_at] = val;
          res.success = 1'b1;
        end else if (free_at >= 0) begin
          store_entry(free_at, key, val);
          res.success = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit_at >= 0) begin
          kv_used[hit_at] = 1'b0;
          kv_count--;
          res.success = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit_at >= 0) begin
          res.value   = kv_val[hit_at];
          res.success = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = kv_count[CNT_PORT_W-1:0];
    res.empty = (kv_count == 0);
    return res;
  endfunction

  // A request is held until the table takes it; the sender then pauses at random between bursts.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [KEY_PORT_W-1:0] key,
                               input logic [VAL_PORT_W-1:0] val);
    int unsigned gap;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    value_in_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_results.push_back(apply_table_op(op, key, val));
    request_total++;
    if (awaited_results[$].success) success_total++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    kv_cap = cap;
    cap_write_total++;
  endtask

  task automatic test_basic_operations();
    issue_request(OP_LOOKUP, '0, '1);
    issue_request(OP_INSERT, '0, '0);
    issue_request(OP_INSERT, '1, '1);
    issue_request(OP_INSERT, '0, 32'h0000_0001);
    issue_request(OP_LOOKUP, '1, '0);
    issue_request(OP_UPDATE, '0, 32'hA5A5_A5A5);
    issue_request(OP_UPDATE, 32'h1234_5678, 32'h0BAD_0BAD);
    issue_request(OP_UPSERT, '0, 32'h5A5A_5A5A);
    issue_request(OP_UPSERT, 32'h1234_5678, 32'h8000_0001);
    issue_request(OP_ERASE, '0, '1);
    issue_request(OP_ERASE, '0, '1);
    issue_request(OP_LOOKUP, '0, '1);
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++) begin
      issue_request(op[OP_W-1:0], '1, '1);
    end
    issue_request(OP_INSERT, 32'hCAFE_F00D, 32'h7FFF_FFFF);
  endtask

  // Slots beyond a lowered capacity keep their entries and their place in the count.
  task automatic test_capacity_limits();
    write_capacity(5'd1);
    issue_request(OP_INSERT, 32'h0F0F_0F0F, 32'h1111_1111);
    issue_request(OP_LOOKUP, '1, '0);
    write_capacity(5'd0);
    issue_request(OP_LOOKUP, 32'hCAFE_F00D, '0);
    issue_request(OP_INSERT, 32'h0F0F_0F0F, 32'h2222_2222);
    issue_request(OP_UPSERT, 32'hCAFE_F00D, 32'h3333_3333);
    write_capacity(5'd31);
    issue_request(OP_INSERT, 32'h0F0F_0F0F, 32'h4444_4444);
    issue_request(OP_LOOKUP, '1, '0);
    write_capacity(5'd2);
    issue_request(OP_ERASE, 32'h1234_5678, '0);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0]      phase_cap [10];
    logic [KEY_PORT_W-1:0] key_pool  [24];
    logic [OP_W-1:0]       op;
    logic [KEY_PORT_W-1:0] key;
    int unsigned           pool_n;
    int unsigned           items;
    int unsigned           roll;
    phase_cap = '{5'd16, 5'd6, 5'd31, 5'd1, 5'd20, 5'd3, 5'd0, 5'd0, 5'd15, 5'd0};
    phase_cap[7] = CAP_W'($urandom_range(31, 0));
    phase_cap[9] = CAP_W'($urandom_range(31, 0));
    foreach (phase_cap[p]) begin
      write_capacity(phase_cap[p]);
      pool_n = $urandom_range(24, 6);
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      items = (phase_cap[p] == 0) ? 30 : 100;
      repeat (items) begin
        roll = $urandom_range(99, 0);
        if (roll < 4) op = OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        else if (roll < 28) op = OP_INSERT;
        else if (roll < 42) op = OP_UPDATE;
        else if (roll < 62) op = OP_UPSERT;
        else if (roll < 82) op = OP_ERASE;
        else op = OP_LOOKUP;
        key = ($urandom_range(9, 0) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1, 0)];
        issue_request(op, key, $urandom);
      end
    end
  endtask

  initial begin : out_stall_pattern
    int unsigned run;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(40, 1);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      if ($urandom_range(3, 0) != 0) begin
        run = $urandom_range(30, 1);
        out_ready_i <= 1'b0;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    kv_result_t want;
    kv_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.success = success_o;
      got.value   = value_out_o;
      got.count   = entry_count_o;
      got.empty   = is_empty_o;
      result_total++;
      if (awaited_results.size() == 0) begin
        mismatch_total++;
        if (mismatch_total <= 10)
          $display("Unexpected result %0d with no request outstanding: %p", result_total, got);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display({"Mismatch on result %0d (expected/actual): success %0b/%0b ",
                      "value %h/%h count %0d/%0d empty %0b/%0b"}, result_total,
                     want.success, got.success, want.value, got.value,
                     want.count, got.count, want.empty, got.empty);
        end
      end
    end
  end

  initial begin
    kv_used    = '{default: 1'b0};
    kv_key     = '{default: '0};
    kv_val     = '{default: '0};
    kv_count   = 0;
    kv_cap     = CAP_RESET;
    burst_left = $urandom_range(24, 1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_operations();
    test_capacity_limits();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 8) @(posedge clk_i);

    $display("Sent %0d table requests over %0d capacity settings; %0d succeeded, %0d failed.",
             request_total, cap_write_total, success_total, request_total - success_total);
    $display("Checked %0d results, %0d mismatches.", result_total, mismatch_total);
    if (mismatch_total == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
